// ----- rtl/core/cwsd_pkg.sv -----
// Shared types and constants of the centered-window spike detector.
package cwsd_pkg;

	localparam int PRICE_W = 32;
	localparam int HW_W    = 5;
	localparam int CFG_W   = 32;

	typedef logic [PRICE_W-1:0] price_t;
	typedef logic [HW_W-1:0]    half_window_t;
	typedef logic [CFG_W-1:0]   cfg_data_t;
	typedef logic signed [1:0]  sig_t;
	typedef logic [0:0]         cfg_index_t;

	typedef struct packed {
		price_t high;
		price_t low;
	} bar_t;

	// register indexes
	localparam cfg_index_t CFG_HALF_WINDOW     = 1'd0;
	localparam cfg_index_t CFG_SPIKE_THRESHOLD = 1'd1;

	// register reset values
	localparam half_window_t HALF_WINDOW_RESET = 5'd10;
	localparam price_t       THRESHOLD_RESET   = 32'd65536;

	// signal codes
	localparam sig_t SIG_NONE = 2'sb00;
	localparam sig_t SIG_UP   = 2'sb01;
	localparam sig_t SIG_DOWN = 2'sb11;

endpackage

// ----- rtl/core/centered_window_spike_detect_core.sv -----
// Top level of the centered-window spike detector: bar history, scan sequencer, classification.
// Flow: a bar still inside the first n of its series goes straight to S_EMIT and returns signal 0;
//   a classified bar passes S_SCAN, S_DECIDE and S_EMIT before its signal is registered out.
// Rate: the scan reads the 2n+1 window entries one per cycle through the single history RAM
//   read port; a new bar is accepted only in S_IDLE, so not during a scan or while S_EMIT waits
//   for the output register; bars that yield no result are taken one per cycle.
// Reset: registers return to their reset values, the bar count and write pointer clear;
//   history RAM is not swept, the bar count marks which entries hold valid bars.
module centered_window_spike_detect_core #(
	parameter int MAX_HALF_WINDOW = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  cwsd_pkg::cfg_index_t     cfg_index,
	input  cwsd_pkg::cfg_data_t      cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  cwsd_pkg::price_t         high_price,
	input  cwsd_pkg::price_t         low_price,
	input  logic                     end_of_series,
	output logic                     out_valid,
	input  logic                     out_ready,
	output cwsd_pkg::sig_t           signal
);

	import cwsd_pkg::*;

	localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int NW    = $clog2(MAX_HALF_WINDOW + 1);
	localparam int KW    = $clog2(2 * MAX_HALF_WINDOW + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;
	localparam logic [1:0] S_EMIT   = 2'd3;

	logic [1:0]    state_q;
	half_window_t  hw_q;
	price_t        thr_q;
	logic [AW-1:0] wp_q;
	logic [CW-1:0] bars_seen_q;
	logic [NW-1:0] n_q;
	logic [KW-1:0] twice_n_q;
	logic [AW-1:0] rd_addr_q;
	logic [KW-1:0] rd_k_q;
	logic          issue_done_q;
	logic          val_s1;
	logic [KW-1:0] k_s1;
	price_t        top_q;
	price_t        bottom_q;
	price_t        ch_q;
	price_t        cl_q;
	sig_t          result_q;
	logic          out_valid_q;
	sig_t          signal_q;

	logic          in_fire;
	logic [NW-1:0] n_eff;
	logic [KW-1:0] twice_n;
	logic          early_bar;
	logic          full_bar;
	logic          issue;
	bar_t          wr_bar;
	bar_t          rd_bar;
	sig_t          decision;
	logic          out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign signal    = signal_q;
	assign out_free  = !out_valid_q || out_ready;

	// clamp the configured half window into 1..MAX_HALF_WINDOW
	always_comb begin
		if (hw_q == '0) begin
			n_eff = NW'(1);
		end else if (int'(hw_q) > MAX_HALF_WINDOW) begin
			n_eff = NW'(MAX_HALF_WINDOW);
		end else begin
			n_eff = NW'(hw_q);
		end
	end

	assign twice_n   = KW'({n_eff, 1'b0});
	assign early_bar = bars_seen_q < CW'(n_eff);
	assign full_bar  = bars_seen_q >= CW'(twice_n);
	assign issue     = (state_q == S_SCAN) && !issue_done_q;

	assign wr_bar.high = high_price;
	assign wr_bar.low  = low_price;

	// history line as a circular buffer, newest bar at the write pointer
	cwsd_ram #(
		.WIDTH($bits(bar_t)),
		.DEPTH(DEPTH)
	) u_line (
		.clk  (clk),
		.we   (in_fire),
		.waddr(wp_q),
		.wdata(wr_bar),
		.re   (issue),
		.raddr(rd_addr_q),
		.rdata(rd_bar)
	);

	// classify the center bar against the window extremes
	always_comb begin
		if (ch_q > top_q && (ch_q - top_q) > thr_q) begin
			decision = SIG_UP;
		end else if (bottom_q > cl_q && (bottom_q - cl_q) > thr_q) begin
			decision = SIG_DOWN;
		end else begin
			decision = SIG_NONE;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q  <= HALF_WINDOW_RESET;
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF_WINDOW:     hw_q  <= cfg_data[HW_W-1:0];
				CFG_SPIKE_THRESHOLD: thr_q <= cfg_data[PRICE_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the write pointer and bar count, clear them at end of series
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			bars_seen_q <= '0;
		end else if (in_fire) begin
			if (end_of_series) begin
				wp_q        <= '0;
				bars_seen_q <= '0;
			end else begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
				if (bars_seen_q < CW'(DEPTH)) begin
					bars_seen_q <= bars_seen_q + CW'(1);
				end
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issue_done_q <= 1'b0;
			val_s1       <= 1'b0;
		end else begin
			val_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						issue_done_q <= 1'b0;
						if (early_bar) begin
							state_q <= S_EMIT;
						end else if (full_bar) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue && rd_k_q == twice_n_q) begin
						issue_done_q <= 1'b1;
					end
					if (val_s1 && k_s1 == twice_n_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// scan datapath: walk ages 0..2n, fold extremes, capture the center
	always_ff @(posedge clk) begin
		if (in_fire) begin
			n_q       <= n_eff;
			twice_n_q <= twice_n;
			rd_addr_q <= wp_q;
			rd_k_q    <= '0;
			top_q     <= '0;
			bottom_q  <= '1;
			result_q  <= SIG_NONE;
		end
		if (issue) begin
			rd_addr_q <= (rd_addr_q == '0) ? AW'(DEPTH - 1) : rd_addr_q - AW'(1);
			rd_k_q    <= rd_k_q + KW'(1);
		end
		k_s1 <= rd_k_q;
		if (val_s1) begin
			if (k_s1 == KW'(n_q)) begin
				ch_q <= rd_bar.high;
				cl_q <= rd_bar.low;
			end else begin
				if (rd_bar.high > top_q) begin
					top_q <= rd_bar.high;
				end
				if (rd_bar.low < bottom_q) begin
					bottom_q <= rd_bar.low;
				end
			end
		end
		if (state_q == S_DECIDE) begin
			result_q <= decision;
		end
	end

	// output register: load when free, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			signal_q <= result_q;
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bars_seen_q <= CW'(DEPTH))
		else $error("bar count past line depth");

	a_eos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && end_of_series |=> bars_seen_q == '0 && wp_q == '0)
		else $error("history not cleared at end of series");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !end_of_series && bars_seen_q < CW'(DEPTH)
		|=> bars_seen_q == $past(bars_seen_q) + CW'(1))
		else $error("bar count did not advance");

	a_sig_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> signal != 2'sb10)
		else $error("illegal signal code");

	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_SCAN |-> !issue)
		else $error("history read outside scan");

endmodule

// ----- rtl/core/cwsd_ram.sv -----
// Generic simple dual-port RAM with registered read.
module cwsd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
